>>> rtl/core/ipv4_tcp_header_parser_assert.svh
// Assertion macros for the checker of the header parser.
`ifndef IPV4_TCP_HEADER_PARSER_ASSERT_SVH
`define IPV4_TCP_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ITHP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("header parser check failed");

// Next-cycle implication, checked out of reset.
`define ITHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("header parser check failed");

`endif

>>> rtl/core/ithp_pkg.sv
// Shared types and constants of the IPv4/TCP header parser.
package ithp_pkg;

    localparam logic [15:0] MAX_PACKET_BYTES   = 16'd65535;
    localparam logic [15:0] TCP_BASE_HDR_BYTES = 16'd20;

    localparam logic [7:0] PROTO_ICMP          = 8'd1;
    localparam logic [7:0] PROTO_TCP           = 8'd6;
    localparam logic [7:0] ICMP_TIME_EXCEEDED  = 8'd11;

    localparam logic [7:0] OPT_NOP             = 8'd1;
    localparam logic [7:0] OPT_MSS             = 8'd2;
    localparam logic [7:0] OPT_TIMESTAMP       = 8'd8;
    localparam logic [7:0] OPT_MIN_LENGTH      = 8'd2;

    localparam logic [1:0] KIND_OTHER          = 2'd0;
    localparam logic [1:0] KIND_TCP            = 2'd1;
    localparam logic [1:0] KIND_ICMP           = 2'd2;
    localparam logic [1:0] KIND_ICMP_TIME_EXC  = 2'd3;

    localparam int OUT_TDATA_W = 264;

    typedef struct packed {
        logic [1:0]  packet_kind;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] sequence_number;
        logic [31:0] ack_number;
        logic [5:0]  tcp_flag_bits;
        logic [15:0] payload_length;
        logic [15:0] mss_value;
        logic [31:0] ts_value;
        logic [31:0] ts_echo;
    } ithp_result_t;

endpackage

>>> rtl/core/ipv4_tcp_header_parser.sv
// Top level of the IPv4/TCP header parser: stream ports and result register.
// Throughput: one packet byte per cycle, except that a last byte waits while a summary is pending.
// The summary request shows on the master side in the cycle after the last byte is accepted.
// A waiting summary stalls only a further last byte; other bytes keep flowing.
// Reset (rst_n low, asynchronous): clear all tracking state and drop any pending summary.
module ipv4_tcp_header_parser
    import ithp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Slave side: one packet byte per request
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,  // [7:0] data_byte
    input  logic                   s_tlast,  // last_byte
    // Master side: one summary request per packet
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] source_address, [63:32] dest_address, [79:64] source_port,
    // [95:80] dest_port, [127:96] sequence_number, [159:128] ack_number,
    // [165:160] tcp_flag_bits, [181:166] payload_length, [197:182] mss_value,
    // [229:198] ts_value, [261:230] ts_echo, [263:262] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [1:0]             m_tuser   // [1:0] packet_kind
);

    logic         accept;
    logic         load;
    ithp_result_t summary;
    logic         out_valid_reg;
    ithp_result_t out_data_reg;

    // Bytes other than the last never produce a request, so only the
    // last byte has to wait for the result register to drain.
    assign s_tready = !out_valid_reg || m_tready || !s_tlast;
    assign accept   = s_tvalid && s_tready;
    assign load     = accept && s_tlast;

    ithp_extract u_extract
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .result    (summary)
    );

    // Hold the summary until the master side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= summary;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.packet_kind;
    assign m_tdata  = {2'b00,
                       out_data_reg.ts_echo,
                       out_data_reg.ts_value,
                       out_data_reg.mss_value,
                       out_data_reg.payload_length,
                       out_data_reg.tcp_flag_bits,
                       out_data_reg.ack_number,
                       out_data_reg.sequence_number,
                       out_data_reg.dest_port,
                       out_data_reg.source_port,
                       out_data_reg.dest_address,
                       out_data_reg.source_address};

endmodule

>>> rtl/core/ithp_extract.sv
// Per-byte header tracking, field capture and TCP option walk.
module ithp_extract
    import ithp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output ithp_result_t result
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_KIND = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_STOP = 4'b1000
    } ithp_phase_t;

    logic [15:0] pos_reg,       pos_next;
    logic [5:0]  ihb_reg,       ihb_next;
    logic [15:0] total_reg,     total_next;
    logic [7:0]  proto_reg,     proto_next;
    logic [5:0]  thb_reg,       thb_next;
    logic [15:0] nop_reg,       nop_next;
    ithp_phase_t phase_reg,     phase_next;
    logic [63:0] addr_reg,      addr_next;
    logic [63:0] seqack_reg,    seqack_next;
    logic [31:0] ports_reg,     ports_next;
    logic [5:0]  flags_reg,     flags_next;
    logic [7:0]  icmp_reg,      icmp_next;
    logic [15:0] mss_val_reg,   mss_val_next;
    logic [15:0] mss_pos_reg,   mss_pos_next;
    logic        mss_found_reg, mss_found_next;
    logic [15:0] ts_pos_reg,    ts_pos_next;
    logic        ts_found_reg,  ts_found_next;
    logic [63:0] ts_reg,        ts_next;

    always_comb
    begin
        logic        active;
        logic        at_tcp;
        logic [15:0] off;
        logic [16:0] pos_w;
        logic [16:0] nxt;
        logic [16:0] ts_dist;
        logic [2:0]  a_idx;
        logic [2:0]  s_idx;

        pos_next       = pos_reg;
        ihb_next       = ihb_reg;
        total_next     = total_reg;
        proto_next     = proto_reg;
        thb_next       = thb_reg;
        nop_next       = nop_reg;
        phase_next     = phase_reg;
        addr_next      = addr_reg;
        seqack_next    = seqack_reg;
        ports_next     = ports_reg;
        flags_next     = flags_reg;
        icmp_next      = icmp_reg;
        mss_val_next   = mss_val_reg;
        mss_pos_next   = mss_pos_reg;
        mss_found_next = mss_found_reg;
        ts_pos_next    = ts_pos_reg;
        ts_found_next  = ts_found_reg;
        ts_next        = ts_reg;

        active  = (pos_reg != MAX_PACKET_BYTES);
        pos_w   = {1'b0, pos_reg};
        a_idx   = 3'(5'd19 - pos_reg[4:0]);
        ts_dist = pos_w - {1'b0, ts_pos_reg} - 17'd2;
        nxt     = {1'b0, nop_reg} + {9'b0, data_byte};

        if (active)
        begin
            pos_next = pos_reg + 16'd1;

            if (pos_reg == 16'd0)
                ihb_next = {data_byte[3:0], 2'b00};
            if (pos_reg == 16'd2)
                total_next[15:8] = data_byte;
            if (pos_reg == 16'd3)
                total_next[7:0] = data_byte;
            if (pos_reg == 16'd9)
                proto_next = data_byte;
            if (pos_reg >= 16'd12 && pos_reg <= 16'd19)
                addr_next[{a_idx, 3'b000} +: 8] = data_byte;

            // Option value bytes follow the kind and length bytes
            if (mss_found_reg)
            begin
                if (pos_w == {1'b0, mss_pos_reg} + 17'd2)
                    mss_val_next[15:8] = data_byte;
                if (pos_w == {1'b0, mss_pos_reg} + 17'd3)
                    mss_val_next[7:0] = data_byte;
            end
            if (ts_found_reg && pos_w >= {1'b0, ts_pos_reg} + 17'd2 &&
                pos_w <= {1'b0, ts_pos_reg} + 17'd9)
                ts_next[{~ts_dist[2:0], 3'b000} +: 8] = data_byte;

            // Option walk: one kind byte, then a length byte unless EOL or NOP
            case (phase_reg)
                PH_KIND:
                begin
                    if (pos_reg == nop_reg)
                    begin
                        if (pos_w >= 17'({ihb_reg} + {thb_reg}))
                            phase_next = PH_STOP;
                        else
                        begin
                            if (data_byte == OPT_MSS && !mss_found_reg)
                            begin
                                mss_found_next = 1'b1;
                                mss_pos_next   = pos_reg;
                            end
                            if (data_byte == OPT_TIMESTAMP && !ts_found_reg)
                            begin
                                ts_found_next = 1'b1;
                                ts_pos_next   = pos_reg;
                            end
                            if (data_byte <= OPT_NOP)
                                nop_next = pos_reg + 16'd1;
                            else
                                phase_next = PH_LEN;
                        end
                    end
                end
                PH_LEN:
                begin
                    if (pos_w == {1'b0, nop_reg} + 17'd1)
                    begin
                        if (data_byte < OPT_MIN_LENGTH || nxt[16])
                            phase_next = PH_STOP;
                        else
                        begin
                            nop_next   = nxt[15:0];
                            phase_next = PH_KIND;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // Transport fields sit behind the IP header as its length says
            at_tcp = (pos_reg >= {10'b0, ihb_next});
            off    = pos_reg - {10'b0, ihb_next};
            s_idx  = 3'(4'd11 - off[3:0]);
            if (at_tcp)
            begin
                if (off == 16'd0)
                    icmp_next = data_byte;
                if (off < 16'd4)
                    ports_next[{~off[1:0], 3'b000} +: 8] = data_byte;
                if (off >= 16'd4 && off < 16'd12)
                    seqack_next[{s_idx, 3'b000} +: 8] = data_byte;
                if (off == 16'd12)
                begin
                    thb_next = {data_byte[7:4], 2'b00};
                    if (thb_next > TCP_BASE_HDR_BYTES[5:0] && phase_reg == PH_IDLE)
                    begin
                        nop_next   = {10'b0, ihb_next} + TCP_BASE_HDR_BYTES;
                        phase_next = PH_KIND;
                    end
                    else
                        phase_next = PH_STOP;
                end
                if (off == 16'd13)
                    flags_next = data_byte[5:0];
            end
        end
    end

    // Summary from the state as it stands after this byte
    always_comb
    begin
        logic        tcp;
        logic [16:0] pay_diff;

        tcp      = (proto_next == PROTO_TCP);
        pay_diff = {1'b0, total_next} - 17'({ihb_next} + {thb_next});

        if (tcp)
            result.packet_kind = KIND_TCP;
        else if (proto_next == PROTO_ICMP)
            result.packet_kind = (icmp_next == ICMP_TIME_EXCEEDED) ? KIND_ICMP_TIME_EXC
                                                                   : KIND_ICMP;
        else
            result.packet_kind = KIND_OTHER;

        result.source_address  = addr_next[63:32];
        result.dest_address    = addr_next[31:0];
        result.source_port     = tcp ? ports_next[31:16] : 16'd0;
        result.dest_port       = tcp ? ports_next[15:0] : 16'd0;
        result.sequence_number = tcp ? seqack_next[63:32] : 32'd0;
        result.ack_number      = tcp ? seqack_next[31:0] : 32'd0;
        result.tcp_flag_bits   = tcp ? flags_next : 6'd0;
        result.payload_length  = (tcp && !pay_diff[16]) ? pay_diff[15:0] : 16'd0;
        result.mss_value       = (tcp && mss_found_next) ? mss_val_next : 16'd0;
        result.ts_value        = (tcp && ts_found_next) ? ts_next[63:32] : 32'd0;
        result.ts_echo         = (tcp && ts_found_next) ? ts_next[31:0] : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ihb_reg       <= '0;
            total_reg     <= '0;
            proto_reg     <= '0;
            thb_reg       <= '0;
            nop_reg       <= '0;
            phase_reg     <= PH_IDLE;
            addr_reg      <= '0;
            seqack_reg    <= '0;
            ports_reg     <= '0;
            flags_reg     <= '0;
            icmp_reg      <= '0;
            mss_val_reg   <= '0;
            mss_pos_reg   <= '0;
            mss_found_reg <= 1'b0;
            ts_pos_reg    <= '0;
            ts_found_reg  <= 1'b0;
            ts_reg        <= '0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                pos_reg       <= '0;
                ihb_reg       <= '0;
                total_reg     <= '0;
                proto_reg     <= '0;
                thb_reg       <= '0;
                nop_reg       <= '0;
                phase_reg     <= PH_IDLE;
                addr_reg      <= '0;
                seqack_reg    <= '0;
                ports_reg     <= '0;
                flags_reg     <= '0;
                icmp_reg      <= '0;
                mss_val_reg   <= '0;
                mss_pos_reg   <= '0;
                mss_found_reg <= 1'b0;
                ts_pos_reg    <= '0;
                ts_found_reg  <= 1'b0;
                ts_reg        <= '0;
            end
            else
            begin
                pos_reg       <= pos_next;
                ihb_reg       <= ihb_next;
                total_reg     <= total_next;
                proto_reg     <= proto_next;
                thb_reg       <= thb_next;
                nop_reg       <= nop_next;
                phase_reg     <= phase_next;
                addr_reg      <= addr_next;
                seqack_reg    <= seqack_next;
                ports_reg     <= ports_next;
                flags_reg     <= flags_next;
                icmp_reg      <= icmp_next;
                mss_val_reg   <= mss_val_next;
                mss_pos_reg   <= mss_pos_next;
                mss_found_reg <= mss_found_next;
                ts_pos_reg    <= ts_pos_next;
                ts_found_reg  <= ts_found_next;
                ts_reg        <= ts_next;
            end
        end
    end

endmodule

>>> rtl/core/ithp_checker.sv
// Port-level checks of the header parser and their binding to the top level.
`include "ipv4_tcp_header_parser_assert.svh"

module ithp_checker
    import ithp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [7:0]             s_tdata,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [1:0]             m_tuser
);

    logic in_last;

    assign in_last = s_tvalid && s_tready && s_tlast && (s_tdata == s_tdata);

    // A stalled summary holds
    `ITHP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A summary only follows an accepted last byte
    `ITHP_ASSERT_NEXT(a_out_cause, !m_tvalid, !m_tvalid || $past(in_last))

    // Every accepted last byte yields a summary
    `ITHP_ASSERT_NEXT(a_out_follows, in_last, m_tvalid)

    // Transport fields and padding are clear for anything but TCP
    `ITHP_ASSERT_NOW(a_non_tcp_clear, m_tvalid && m_tuser != KIND_TCP, m_tdata[OUT_TDATA_W-1:64] == '0)

endmodule

bind ipv4_tcp_header_parser ithp_checker u_checker (.*);
